// ===== rtl/core/vdcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdcp_pkg
// Shared constants and types for the frame checker and command classifier.
// ----------------------------------------------------------------------------
package vdcp_pkg;

  localparam logic [7:0] HEADER_BYTE   = 8'h02;
  localparam logic [7:0] NEW_PROTO_BIT = 8'h80;
  localparam logic [8:0] POS_MAX       = 9'd511;

  // command groups (first command byte)
  localparam logic [7:0] GRP_SYSTEM  = 8'h10;
  localparam logic [7:0] GRP_PRESET  = 8'h20;
  localparam logic [7:0] GRP_SENSE   = 8'h30;

  // second command bytes, per group
  localparam logic [7:0] SUB_STOP        = 8'h00;
  localparam logic [7:0] SUB_PLAY        = 8'h01;
  localparam logic [7:0] SUB_STILL       = 8'h04;
  localparam logic [7:0] SUB_CONTINUE    = 8'h06;
  localparam logic [7:0] SUB_CUE         = 8'h24;
  localparam logic [7:0] SUB_CUE_DATA    = 8'h25;
  localparam logic [7:0] SUB_ACK_A       = 8'h21;
  localparam logic [7:0] SUB_ACK_B       = 8'h22;
  localparam logic [7:0] SUB_PORT_STATUS = 8'h05;
  localparam logic [7:0] SUB_SIZE        = 8'h14;
  localparam logic [7:0] SUB_ID_EXISTS   = 8'h16;
  localparam logic [7:0] SUB_ID_LIST     = 8'h11;
  localparam logic [7:0] SUB_NEXT        = 8'h02;
  localparam logic [7:0] SUB_OPEN_PORT   = 8'h01;

  // frame verdicts
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_LEN_ERR   = 3'd3;
  localparam logic [2:0] ST_SUM_ERR   = 3'd4;

  // command codes
  localparam logic [3:0] CMD_NAK         = 4'd0;
  localparam logic [3:0] CMD_CUE         = 4'd1;
  localparam logic [3:0] CMD_CUE_DATA    = 4'd2;
  localparam logic [3:0] CMD_PLAY        = 4'd3;
  localparam logic [3:0] CMD_STOP        = 4'd4;
  localparam logic [3:0] CMD_PORT_STATUS = 4'd5;
  localparam logic [3:0] CMD_SIZE        = 4'd6;
  localparam logic [3:0] CMD_ID_EXISTS   = 4'd7;
  localparam logic [3:0] CMD_STILL       = 4'd8;
  localparam logic [3:0] CMD_CONTINUE    = 4'd9;
  localparam logic [3:0] CMD_ID_LIST     = 4'd10;
  localparam logic [3:0] CMD_NEXT        = 4'd11;
  localparam logic [3:0] CMD_OPEN_PORT   = 4'd12;
  localparam logic [3:0] CMD_ACK         = 4'd13;

  typedef struct packed {
    logic [3:0] code;
    logic       chan;
    logic       newp;
  } cls_t;

endpackage
`default_nettype wire

// ===== rtl/core/vdcp_cls.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdcp_cls
// Strips the new-protocol bit and maps a command byte pair to a code.
// ----------------------------------------------------------------------------
module vdcp_cls
  import vdcp_pkg::*;
(
  input  wire logic [7:0] cmd1,
  input  wire logic [7:0] cmd2,
  output cls_t            cls
);

  logic [7:0] c1;

  always_comb begin
    cls = '0;
    c1  = cmd1;
    if (cmd1 > NEW_PROTO_BIT) begin
      c1       = cmd1 - NEW_PROTO_BIT;
      cls.newp = 1'b1;
    end
    case (c1)
      GRP_SYSTEM: begin
        case (cmd2)
          SUB_STOP:     begin cls.code = CMD_STOP;     cls.chan = 1'b1; end
          SUB_PLAY:     begin cls.code = CMD_PLAY;     cls.chan = 1'b1; end
          SUB_STILL:    begin cls.code = CMD_STILL;    cls.chan = 1'b1; end
          SUB_CONTINUE: begin cls.code = CMD_CONTINUE; cls.chan = 1'b1; end
          default: cls.code = CMD_NAK;
        endcase
      end
      GRP_PRESET: begin
        case (cmd2)
          SUB_CUE:      begin cls.code = CMD_CUE;      cls.chan = 1'b1; end
          SUB_CUE_DATA: begin cls.code = CMD_CUE_DATA; cls.chan = 1'b1; end
          SUB_ACK_A: cls.code = CMD_ACK;
          SUB_ACK_B: cls.code = CMD_ACK;
          default: cls.code = CMD_NAK;
        endcase
      end
      GRP_SENSE: begin
        case (cmd2)
          SUB_PORT_STATUS: begin cls.code = CMD_PORT_STATUS; cls.chan = 1'b1; end
          SUB_SIZE:      cls.code = CMD_SIZE;
          SUB_ID_EXISTS: cls.code = CMD_ID_EXISTS;
          SUB_ID_LIST:   cls.code = CMD_ID_LIST;
          SUB_NEXT:      cls.code = CMD_NEXT;
          SUB_OPEN_PORT: cls.code = CMD_OPEN_PORT;
          default: cls.code = CMD_NAK;
        endcase
      end
      default: cls.code = CMD_NAK;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/vdcp_frame_check_classify_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdcp_frame_check_classify_core
// Checks VDCP frames byte by byte and classifies valid commands.
// ----------------------------------------------------------------------------
// result: an end-of-message byte is held in the input register, then its verdict is registered
// throughput: one byte per cycle, set by the input register and result register
// pair; a waiting result stalls input only once both registers are full
// reset: synchronous rst clears the byte counter, frame state, the stored
// open port data and both valid flags
module vdcp_frame_check_classify_core
  import vdcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       frame_status,
  output logic [3:0]       command_code,
  output logic             channel_command,
  output logic             new_protocol,
  output logic             open_port_known,
  output logic [15:0]      open_port_data
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eom;

  // frame state
  logic [8:0]  byte_position;
  logic [7:0]  header_value;
  logic [7:0]  declared_count;
  logic [7:0]  running_sum;
  logic [7:0]  first_command;
  logic [7:0]  second_command;
  logic [15:0] pending_port_data;
  logic [15:0] stored_port_data;
  logic        stored_port_valid;

  logic [8:0]  total;
  logic [7:0]  header_next;
  logic [7:0]  count_next;
  logic [7:0]  sum_next;
  logic [7:0]  cmd1_next;
  logic [7:0]  cmd2_next;
  logic [15:0] pending_next;
  logic [8:0]  count_p1;
  logic [9:0]  count_p3;
  logic [2:0]  status;
  logic        advance;
  cls_t        cls;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  assign count_p1 = {1'b0, declared_count} + 9'd1;

  always_comb begin
    header_next  = header_value;
    sum_next     = running_sum + s1_byte;
    count_next   = declared_count;
    cmd1_next    = first_command;
    cmd2_next    = second_command;
    pending_next = pending_port_data;
    if (byte_position == 9'd0) begin
      header_next  = s1_byte;
      sum_next     = 8'd0;
      pending_next = 16'd0;
    end
    if (byte_position == 9'd1) count_next = s1_byte;
    if (byte_position == 9'd2) cmd1_next = s1_byte;
    if (byte_position == 9'd3) cmd2_next = s1_byte;
    // a data byte beyond the declared count is left at zero
    if (byte_position == 9'd4 && byte_position <= count_p1) pending_next[15:8] = s1_byte;
    if (byte_position == 9'd5 && byte_position <= count_p1) pending_next[7:0] = s1_byte;
    total = (byte_position < POS_MAX) ? byte_position + 9'd1 : POS_MAX;
  end

  assign count_p3 = {2'b00, count_next} + 10'd3;

  always_comb begin
    if (total < 9'd5)                     status = ST_SHORT;
    else if (header_next != HEADER_BYTE)  status = ST_BAD_HDR;
    else if ({1'b0, total} != count_p3)   status = ST_LEN_ERR;
    else if (sum_next != 8'd0)            status = ST_SUM_ERR;
    else                                  status = ST_OK;
  end

  vdcp_cls u_cls (
    .cmd1 (cmd1_next),
    .cmd2 (cmd2_next),
    .cls  (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      byte_position     <= 9'd0;
      header_value      <= 8'd0;
      declared_count    <= 8'd0;
      running_sum       <= 8'd0;
      first_command     <= 8'd0;
      second_command    <= 8'd0;
      pending_port_data <= 16'd0;
      stored_port_data  <= 16'd0;
      stored_port_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
        s1_byte  <= data_byte;
        s1_eom   <= end_of_message;
      end
      if (out_ready) out_valid <= 1'b0;
      if (advance) begin
        header_value      <= header_next;
        declared_count    <= count_next;
        running_sum       <= sum_next;
        first_command     <= cmd1_next;
        second_command    <= cmd2_next;
        pending_port_data <= pending_next;
        byte_position     <= s1_eom ? 9'd0 : total;
        if (s1_eom) begin
          out_valid       <= 1'b1;
          frame_status    <= status;
          command_code    <= CMD_NAK;
          channel_command <= 1'b0;
          new_protocol    <= 1'b0;
          open_port_known <= 1'b0;
          open_port_data  <= 16'd0;
          if (status == ST_OK) begin
            command_code    <= cls.code;
            channel_command <= cls.chan;
            new_protocol    <= cls.newp;
            if (cls.code == CMD_OPEN_PORT) begin
              stored_port_data  <= pending_next;
              stored_port_valid <= 1'b1;
            end
            if (cls.code == CMD_PORT_STATUS) begin
              open_port_known <= stored_port_valid;
              open_port_data  <= stored_port_data;
            end
          end
        end
      end
    end
  end

  // a failed frame carries no command
  a_fail_nak: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status != ST_OK |-> command_code == CMD_NAK && !channel_command
      && !new_protocol)
    else $error("failed frame carries a command");

  // port data only comes with a valid port status
  a_port_only_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (open_port_known || open_port_data != 16'd0)
      |-> frame_status == ST_OK && command_code == CMD_PORT_STATUS)
    else $error("port data outside port status");

  // a result only appears after a message end was taken from the input register
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(advance && s1_eom))
    else $error("result without message end");

endmodule
`default_nettype wire

// ===== bench/tb_vdcp_frame_check_classify_core.sv =====
// ----------------------------------------------------------------------------
// tb_vdcp_frame_check_classify_core
// Sends VDCP messages byte by byte: well-formed frames for every command,
// frames with a bad header, a wrong count, a bad checksum or too few bytes,
// raw noise and overlong messages. A model of the frame checker predicts the
// verdict for each end-of-message byte and the result stream is checked in
// order, under random idling on both sides and long output stalls.
// ----------------------------------------------------------------------------
module tb_vdcp_frame_check_classify_core;
  import vdcp_pkg::*;

  localparam int NUM_PAIRS    = 14;
  localparam int TARGET_BYTES = 1850;
  localparam int LONG_HOLD    = 200;

  typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_LENGTH, FLAW_SUM, FLAW_SHORT} flaw_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  code;
    logic        chan;
    logic        newp;
    logic        known;
    logic [15:0] pdata;
  } verdict_t;

  class frame_verdict_board;
    logic [8:0]  byte_pos;
    logic [7:0]  hdr;
    logic [7:0]  count;
    logic [7:0]  sum;
    logic [7:0]  cmd_a;
    logic [7:0]  cmd_b;
    logic [15:0] pending_port;
    logic [15:0] saved_port;
    logic        saved_valid;
    verdict_t    pending_verdicts[$];
    int          errors;

    function new();
      byte_pos     = '0;
      hdr          = '0;
      count        = '0;
      sum          = '0;
      cmd_a        = '0;
      cmd_b        = '0;
      pending_port = '0;
      saved_port   = '0;
      saved_valid  = 1'b0;
      errors       = 0;
    endfunction

    function cls_t classify(logic [7:0] c1, logic [7:0] c2);
      cls_t c;
      c = '0;
      // strip the new protocol bit, but not from a bare 0x80
      if (c1 > NEW_PROTO_BIT) begin
        c1 = c1 - NEW_PROTO_BIT;
        c.newp = 1'b1;
      end
      case (c1)
        GRP_SYSTEM: begin
          case (c2)
            SUB_STOP:     begin c.code = CMD_STOP;     c.chan = 1'b1; end
            SUB_PLAY:     begin c.code = CMD_PLAY;     c.chan = 1'b1; end
            SUB_STILL:    begin c.code = CMD_STILL;    c.chan = 1'b1; end
            SUB_CONTINUE: begin c.code = CMD_CONTINUE; c.chan = 1'b1; end
            default:      c.code = CMD_NAK;
          endcase
        end
        GRP_PRESET: begin
          case (c2)
            SUB_CUE:      begin c.code = CMD_CUE;      c.chan = 1'b1; end
            SUB_CUE_DATA: begin c.code = CMD_CUE_DATA; c.chan = 1'b1; end
            SUB_ACK_A:    c.code = CMD_ACK;
            SUB_ACK_B:    c.code = CMD_ACK;
            default:      c.code = CMD_NAK;
          endcase
        end
        GRP_SENSE: begin
          case (c2)
            SUB_PORT_STATUS: begin c.code = CMD_PORT_STATUS; c.chan = 1'b1; end
            SUB_SIZE:        c.code = CMD_SIZE;
            SUB_ID_EXISTS:   c.code = CMD_ID_EXISTS;
            SUB_ID_LIST:     c.code = CMD_ID_LIST;
            SUB_NEXT:        c.code = CMD_NEXT;
            SUB_OPEN_PORT:   c.code = CMD_OPEN_PORT;
            default:         c.code = CMD_NAK;
          endcase
        end
        default: c.code = CMD_NAK;
      endcase
      return c;
    endfunction

    function void take_byte(logic [7:0] b, logic eom);
      logic [8:0] total;
      cls_t       cls;
      verdict_t   v;
      if (byte_pos == 9'd0) begin
        hdr          = b;
        sum          = 8'h00;
        pending_port = 16'h0000;
      end else begin
        sum = sum + b;
      end
      if (byte_pos == 9'd1) count = b;
      if (byte_pos == 9'd2) cmd_a = b;
      if (byte_pos == 9'd3) cmd_b = b;
      // port data bytes past the declared count read as zero
      if (byte_pos == 9'd4 && 4 <= int'(count) + 1) pending_port[15:8] = b;
      if (byte_pos == 9'd5 && 5 <= int'(count) + 1) pending_port[7:0] = b;
      total    = (byte_pos < POS_MAX) ? byte_pos + 9'd1 : POS_MAX;
      byte_pos = total;
      if (!eom) return;

      byte_pos = '0;
      v = '0;
      if (total < 9'd5) v.status = ST_SHORT;
      else if (hdr != HEADER_BYTE) v.status = ST_BAD_HDR;
      else if (int'(total) != int'(count) + 3) v.status = ST_LEN_ERR;
      else if (sum != 8'h00) v.status = ST_SUM_ERR;
      else v.status = ST_OK;

      if (v.status == ST_OK) begin
        cls    = classify(cmd_a, cmd_b);
        v.code = cls.code;
        v.chan = cls.chan;
        v.newp = cls.newp;
        if (cls.code == CMD_OPEN_PORT) begin
          saved_port  = pending_port;
          saved_valid = 1'b1;
        end
        if (cls.code == CMD_PORT_STATUS) begin
          v.known = saved_valid;
          v.pdata = saved_port;
        end
      end
      pending_verdicts.insert(pending_verdicts.size(), v);
    endfunction

    function void compare_field(string tag, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("frame_status", want.status, got.status);
      compare_field("command_code", want.code, got.code);
      compare_field("channel_command", want.chan, got.chan);
      compare_field("new_protocol", want.newp, got.newp);
      compare_field("open_port_known", want.known, got.known);
      compare_field("open_port_data", want.pdata, got.pdata);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  frame_status;
  logic [3:0]  command_code;
  logic        channel_command;
  logic        new_protocol;
  logic        open_port_known;
  logic [15:0] open_port_data;

  frame_verdict_board board;
  logic [7:0]         frame_bytes[$];
  bit                 quiet;
  int                 hold_request;
  int                 bytes_sent;

  vdcp_frame_check_classify_core DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .end_of_message  (end_of_message),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_status    (frame_status),
    .command_code    (command_code),
    .channel_command (channel_command),
    .new_protocol    (new_protocol),
    .open_port_known (open_port_known),
    .open_port_data  (open_port_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, plus a long hold when the sender asks for one
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 11) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_verdict({frame_status, command_code, channel_command, new_protocol,
                           open_port_known, open_port_data});
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(0, 99) < 11) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    board.take_byte(b, eom);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  task automatic make_frame(input logic [7:0] c1, input logic [7:0] c2, input int ndata,
                            input flaw_t flaw);
    logic [7:0] csum;
    logic [7:0] bad;
    int         i;
    int         keep;
    frame_bytes.delete();
    add_byte(HEADER_BYTE);
    add_byte(8'(ndata + 2));
    add_byte(c1);
    add_byte(c2);
    repeat (ndata) add_byte(8'($urandom));
    csum = 8'h00;
    for (i = 1; i < frame_bytes.size(); i++) csum = csum - frame_bytes[i];
    if (flaw == FLAW_SUM) csum = csum ^ 8'($urandom_range(1, 255));
    add_byte(csum);
    case (flaw)
      FLAW_HEADER: begin
        do bad = 8'($urandom); while (bad == HEADER_BYTE);
        frame_bytes[0] = bad;
      end
      FLAW_LENGTH: frame_bytes[1] = frame_bytes[1] + 8'($urandom_range(1, 255));
      FLAW_SHORT: begin
        keep = $urandom_range(1, 4);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] listed_pair(int idx);
    case (idx)
      0:       return {GRP_SYSTEM, SUB_STOP};
      1:       return {GRP_SYSTEM, SUB_PLAY};
      2:       return {GRP_SYSTEM, SUB_STILL};
      3:       return {GRP_SYSTEM, SUB_CONTINUE};
      4:       return {GRP_PRESET, SUB_CUE};
      5:       return {GRP_PRESET, SUB_CUE_DATA};
      6:       return {GRP_PRESET, SUB_ACK_A};
      7:       return {GRP_PRESET, SUB_ACK_B};
      8:       return {GRP_SENSE, SUB_SIZE};
      9:       return {GRP_SENSE, SUB_ID_EXISTS};
      10:      return {GRP_SENSE, SUB_ID_LIST};
      11:      return {GRP_SENSE, SUB_NEXT};
      12:      return {GRP_SENSE, SUB_OPEN_PORT};
      default: return {GRP_SENSE, SUB_PORT_STATUS};
    endcase
  endfunction

  task automatic pick_pair(output logic [7:0] c1, output logic [7:0] c2);
    int          r;
    logic [15:0] lp;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      {c1, c2} = listed_pair($urandom_range(0, NUM_PAIRS - 1));
      if ($urandom_range(0, 1)) c1 = c1 | NEW_PROTO_BIT;
    end else if (r < 85) begin
      case ($urandom_range(0, 2))
        0:       c1 = GRP_SYSTEM;
        1:       c1 = GRP_PRESET;
        default: c1 = GRP_SENSE;
      endcase
      c2 = 8'($urandom);
    end else if (r < 90) begin
      c1 = NEW_PROTO_BIT;
      lp = listed_pair($urandom_range(0, NUM_PAIRS - 1));
      c2 = lp[7:0];
    end else begin
      c1 = 8'($urandom);
      c2 = 8'($urandom);
    end
  endtask

  initial begin
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [15:0] pair;
    int          i;
    int          r;
    int          ndata;
    int          msg_idx;
    int          overlong_left;
    board          = new();
    quiet          = 1'b0;
    hold_request   = 0;
    bytes_sent     = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_byte      = 8'h00;
    end_of_message = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single header byte, then a truncated message
    frame_bytes.delete();
    add_byte(HEADER_BYTE);
    send_frame();
    make_frame(GRP_SENSE, SUB_PORT_STATUS, 0, FLAW_SHORT);
    send_frame();
    // port status before any open port
    make_frame(GRP_SENSE, SUB_PORT_STATUS, 0, FLAW_NONE);
    send_frame();
    // open port without data bytes stores zero
    make_frame(GRP_SENSE, SUB_OPEN_PORT, 0, FLAW_NONE);
    send_frame();
    make_frame(GRP_SENSE, SUB_PORT_STATUS, 0, FLAW_NONE);
    send_frame();
    // failed open port must not touch the stored data
    make_frame(GRP_SENSE, SUB_OPEN_PORT, 2, FLAW_SUM);
    send_frame();
    make_frame(GRP_SENSE, SUB_PORT_STATUS, 0, FLAW_NONE);
    send_frame();
    make_frame(GRP_SENSE | NEW_PROTO_BIT, SUB_OPEN_PORT, 2, FLAW_NONE);
    send_frame();
    make_frame(GRP_SENSE | NEW_PROTO_BIT, SUB_PORT_STATUS, 1, FLAW_NONE);
    send_frame();
    // one data byte only: low byte of the port data reads as zero
    make_frame(GRP_SENSE, SUB_OPEN_PORT, 1, FLAW_NONE);
    send_frame();
    make_frame(GRP_SENSE, SUB_PORT_STATUS, 0, FLAW_NONE);
    send_frame();
    make_frame(GRP_SYSTEM, SUB_PLAY, 0, FLAW_HEADER);
    send_frame();
    make_frame(GRP_SYSTEM, SUB_PLAY, 1, FLAW_LENGTH);
    send_frame();
    for (i = 0; i < NUM_PAIRS; i++) begin
      pair = listed_pair(i);
      make_frame(pair[15:8] | ((i % 2) ? NEW_PROTO_BIT : 8'h00), pair[7:0], i % 3, FLAW_NONE);
      send_frame();
    end
    // bare 0x80 is not stripped, 0xFF strips to an unknown group
    make_frame(NEW_PROTO_BIT, SUB_PORT_STATUS, 0, FLAW_NONE);
    send_frame();
    make_frame(8'hFF, 8'hFF, 0, FLAW_NONE);
    send_frame();
    frame_bytes.delete();
    repeat (5) add_byte(8'h00);
    send_frame();

    msg_idx       = 0;
    overlong_left = 2;
    while (bytes_sent < TARGET_BYTES) begin
      quiet = (msg_idx >= 120 && msg_idx < 170);
      if (msg_idx == 30 || msg_idx == 200) hold_request = LONG_HOLD;
      pick_pair(c1, c2);
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 199) == 0) ndata = 253;
      else if ($urandom_range(0, 9) < 8) ndata = $urandom_range(0, 4);
      else ndata = $urandom_range(5, 20);
      if (r < 60) begin
        make_frame(c1, c2, ndata, FLAW_NONE);
      end else if (r < 70) begin
        make_frame(c1, c2, ndata, FLAW_SUM);
      end else if (r < 77) begin
        make_frame(c1, c2, ndata, FLAW_LENGTH);
      end else if (r < 83) begin
        make_frame(c1, c2, ndata, FLAW_HEADER);
      end else if (r < 90) begin
        make_frame(c1, c2, ndata, FLAW_SHORT);
      end else if (r < 99 || overlong_left == 0) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      end else begin
        // long enough for the byte counter to saturate
        overlong_left--;
        frame_bytes.delete();
        add_byte(HEADER_BYTE);
        repeat (519) add_byte(8'($urandom));
      end
      send_frame();
      msg_idx++;
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
